FILE: src/scs_pkg.sv
// shared types and constants of the shift cut sequencer
// item layouts for the channels, register indexes, state and reason codes
// no dependencies
package scs_pkg;

	typedef struct packed {
		logic        operation;
		logic        trigger_pressed;
		logic [15:0] rpm;
		logic [31:0] now_ms;
		logic [2:0]  band_index;
		logic [15:0] band_rpm_low;
		logic [15:0] band_rpm_high;
		logic [15:0] band_cut_ms;
	} in_item_t;

	typedef struct packed {
		logic        cut_fire;
		logic        cut_on_ignition;
		logic [15:0] cut_length_ms;
		logic        backfire_active;
		logic [1:0]  machine_state;
		logic [15:0] holdoff_left_ms;
		logic [2:0]  reason_code;
		logic [15:0] previous_cut_ms;
		logic        ready_to_cut;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_item_t;

	typedef struct packed {
		logic [15:0] rpm_low;
		logic [15:0] rpm_high;
		logic [15:0] cut_ms;
	} band_t;

	// operations of an input transaction
	localparam logic OP_TICK       = 1'b0;
	localparam logic OP_BAND_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_OPTION_BITS     = 3'd0;
	localparam logic [2:0] REG_MANUAL_CUT      = 3'd1;
	localparam logic [2:0] REG_RPM_MINIMUM     = 3'd2;
	localparam logic [2:0] REG_BACKFIRE_RPM    = 3'd3;
	localparam logic [2:0] REG_BACKFIRE_EXTRA  = 3'd4;
	localparam logic [2:0] REG_HOLDOFF         = 3'd5;
	localparam logic [2:0] REG_BAND_COUNT      = 3'd6;

	// register reset values
	localparam logic [2:0]  OPTION_RESET       = 3'd0;
	localparam logic [15:0] MANUAL_CUT_RESET   = 16'd60;
	localparam logic [15:0] RPM_MIN_RESET      = 16'd3000;
	localparam logic [15:0] BF_RPM_RESET       = 16'd6000;
	localparam logic [15:0] BF_EXTRA_RESET     = 16'd0;
	localparam logic [15:0] HOLDOFF_RESET      = 16'd200;
	localparam logic [3:0]  BAND_COUNT_RESET   = 4'd1;

	// option bit positions
	localparam int OPT_AUTO     = 0;
	localparam int OPT_IGNITION = 1;
	localparam int OPT_BACKFIRE = 2;

	// reported machine state codes
	localparam logic [1:0] MS_IDLE    = 2'd0;
	localparam logic [1:0] MS_ARMED   = 2'd1;
	localparam logic [1:0] MS_RECOVER = 2'd2;

	// reason codes
	localparam logic [2:0] RS_OK        = 3'd0;
	localparam logic [2:0] RS_TRIGGERED = 3'd1;
	localparam logic [2:0] RS_BELOW     = 3'd2;
	localparam logic [2:0] RS_CUTTING   = 3'd3;
	localparam logic [2:0] RS_HOLDOFF   = 3'd4;

	// shift sequence state held in the datapath
	typedef enum logic [2:0] {
		CS_IDLE    = 3'b001,
		CS_ARMED   = 3'b010,
		CS_RECOVER = 3'b100
	} cut_state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic clr_idx;
		logic rd_en;
		logic step_idx;
		logic take_cut;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic needs_search;
		logic band_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

FILE: src/scs_if.sv
// channel interfaces of the shift cut sequencer: input, result and config write
// each carries valid, ready and a payload struct from scs_pkg
interface scs_in_if import scs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface scs_out_if import scs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface scs_cfg_if import scs_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: src/scs_ram.sv
// generic single write port ram with registered read
// no dependencies
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: src/scs_ctrl.sv
// sequencing controller of the shift cut sequencer
// depends on scs_pkg for the command and status structs
module scs_ctrl import scs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);
	typedef enum logic [4:0] {
		SQ_IDLE = 5'b00001,
		SQ_EVAL = 5'b00010,
		SQ_READ = 5'b00100,
		SQ_CMP  = 5'b01000,
		SQ_DONE = 5'b10000
	} seq_state_t;

	seq_state_t state_q;
	seq_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			SQ_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = SQ_EVAL;
				end
			end
			SQ_EVAL: begin
				cmd.clr_idx = 1'b1;
				state_d     = sts.needs_search ? SQ_READ : SQ_DONE;
			end
			SQ_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = SQ_CMP;
			end
			SQ_CMP: begin
				// first matching band, or the last band in use
				if (sts.band_done) begin
					cmd.take_cut = 1'b1;
					state_d      = SQ_DONE;
				end else begin
					cmd.step_idx = 1'b1;
					state_d      = SQ_READ;
				end
			end
			SQ_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: src/scs_datapath.sv
// datapath of the shift cut sequencer: config registers, sequence state,
// band table ram, length selection and the result register
// depends on scs_pkg, scs_if and scs_ram
module scs_datapath import scs_pkg::*; #(
	parameter int BAND_DEPTH = 8,
	parameter int CUT_MIN_MS = 10,
	parameter int CUT_MAX_MS = 200
) (
	input  logic          clk,
	input  logic          arst_n,
	scs_in_if.sink        in_ch,
	scs_out_if.source     out_ch,
	scs_cfg_if.sink       cfg_ch,
	input  ctrl_cmd_t     cmd,
	output ctrl_sts_t     sts
);
	localparam int AW = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
	localparam int CW = (AW + 1 > 4) ? AW + 1 : 4;
	localparam logic [CW-1:0] DEPTH_C   = CW'(BAND_DEPTH);
	localparam logic [15:0]   CUT_MIN_C = 16'(CUT_MIN_MS);
	localparam logic [15:0]   CUT_MAX_C = 16'(CUT_MAX_MS);

	// configuration registers
	logic [2:0]  option_q;
	logic [15:0] manual_cut_q;
	logic [15:0] rpm_min_q;
	logic [15:0] bf_rpm_q;
	logic [15:0] bf_extra_q;
	logic [15:0] holdoff_q;
	logic [3:0]  band_count_q;

	// sequence state
	cut_state_t  cstate_q;
	logic [31:0] entry_time_q;
	logic [15:0] last_cut_q;
	logic [15:0] holdoff_left_q;
	logic [2:0]  reason_q;

	// item in progress and search
	in_item_t    item_q;
	logic [AW-1:0] idx_q;
	logic [15:0] pick_q;
	logic        out_valid_q;
	out_item_t   out_q;

	// band table
	logic        ram_we;
	band_t       wr_band;
	band_t       rd_band;

	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] eff_count;
	logic [CW-1:0] last_idx;
	logic          band_hit;
	logic          is_tick;
	logic          rpm_ok;

	logic [15:0] base_len;
	logic [15:0] bf_sum;
	logic [15:0] bf_len;
	logic [15:0] pre_len;
	logic [15:0] cut_len;
	logic        bf_on;
	logic [31:0] elapsed;
	logic        holdoff_done;
	logic [15:0] hold_rem;

	cut_state_t  cstate_d;
	logic [31:0] entry_time_d;
	logic [15:0] last_cut_d;
	logic [15:0] holdoff_left_d;
	logic [2:0]  reason_d;
	out_item_t   res;

	assign in_ch.ready  = cmd.in_ready;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	assign is_tick = (item_q.operation == OP_TICK);
	assign rpm_ok  = (item_q.rpm >= rpm_min_q);

	// band count 0 acts as 1, above the table depth acts as the depth
	assign cnt_ext   = CW'(band_count_q);
	assign eff_count = (cnt_ext == '0) ? CW'(1) : ((cnt_ext > DEPTH_C) ? DEPTH_C : cnt_ext);
	assign last_idx  = eff_count - CW'(1);
	assign band_hit  = (item_q.rpm >= rd_band.rpm_low) && (item_q.rpm < rd_band.rpm_high);

	assign sts.in_valid     = in_ch.valid;
	assign sts.needs_search = is_tick && (cstate_q == CS_ARMED) && rpm_ok && option_q[OPT_AUTO];
	assign sts.band_done    = band_hit || (CW'(idx_q) == last_idx);
	assign sts.out_free     = !out_valid_q || out_ch.ready;

	assign wr_band.rpm_low  = item_q.band_rpm_low;
	assign wr_band.rpm_high = item_q.band_rpm_high;
	assign wr_band.cut_ms   = item_q.band_cut_ms;
	assign ram_we = cmd.commit && (item_q.operation == OP_BAND_WRITE) &&
		(CW'(item_q.band_index) < DEPTH_C);

	scs_ram #(
		.WIDTH($bits(band_t)),
		.DEPTH(BAND_DEPTH)
	) u_band_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(item_q.band_index)),
		.wdata(wr_band),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rd_band)
	);

	// cut length: backfire sum wraps at 16 bits and is limited before the clamp
	assign base_len = option_q[OPT_AUTO] ? pick_q : manual_cut_q;
	assign bf_on    = option_q[OPT_BACKFIRE] && (item_q.rpm >= bf_rpm_q);
	assign bf_sum   = base_len + bf_extra_q;
	assign bf_len   = (bf_sum > CUT_MAX_C) ? CUT_MAX_C : bf_sum;
	assign pre_len  = bf_on ? bf_len : base_len;
	assign cut_len  = (pre_len < CUT_MIN_C) ? CUT_MIN_C :
		((pre_len > CUT_MAX_C) ? CUT_MAX_C : pre_len);

	assign elapsed      = item_q.now_ms - entry_time_q;
	assign holdoff_done = (elapsed >= {16'd0, holdoff_q});
	assign hold_rem     = holdoff_q - elapsed[15:0];

	always_comb begin
		cstate_d       = cstate_q;
		entry_time_d   = entry_time_q;
		last_cut_d     = last_cut_q;
		holdoff_left_d = holdoff_left_q;
		reason_d       = reason_q;
		res            = '0;
		if (is_tick) begin
			case (cstate_q)
				CS_ARMED: begin
					if (!rpm_ok) begin
						reason_d = RS_BELOW;
						cstate_d = CS_IDLE;
					end else begin
						res.cut_fire        = 1'b1;
						res.cut_on_ignition = option_q[OPT_IGNITION] || bf_on;
						res.backfire_active = bf_on;
						res.cut_length_ms   = cut_len;
						last_cut_d          = cut_len;
						reason_d            = RS_CUTTING;
						cstate_d            = CS_RECOVER;
						entry_time_d        = item_q.now_ms;
					end
				end
				CS_RECOVER: begin
					if (holdoff_done) begin
						cstate_d       = CS_IDLE;
						reason_d       = RS_OK;
						holdoff_left_d = '0;
					end else begin
						holdoff_left_d = hold_rem;
						reason_d       = RS_HOLDOFF;
					end
				end
				default: begin
					cstate_d = CS_IDLE;
					if (item_q.trigger_pressed) begin
						cstate_d     = CS_ARMED;
						entry_time_d = item_q.now_ms;
						reason_d     = RS_TRIGGERED;
					end
				end
			endcase
			res.ready_to_cut = (cstate_d == CS_IDLE) && rpm_ok;
		end
		case (cstate_d)
			CS_ARMED:   res.machine_state = MS_ARMED;
			CS_RECOVER: res.machine_state = MS_RECOVER;
			default:    res.machine_state = MS_IDLE;
		endcase
		res.holdoff_left_ms = holdoff_left_d;
		res.reason_code     = reason_d;
		res.previous_cut_ms = last_cut_d;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && cmd.in_ready) begin
			item_q <= in_ch.payload;
		end
		if (cmd.take_cut) begin
			pick_q <= rd_band.cut_ms;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_q       <= OPTION_RESET;
			manual_cut_q   <= MANUAL_CUT_RESET;
			rpm_min_q      <= RPM_MIN_RESET;
			bf_rpm_q       <= BF_RPM_RESET;
			bf_extra_q     <= BF_EXTRA_RESET;
			holdoff_q      <= HOLDOFF_RESET;
			band_count_q   <= BAND_COUNT_RESET;
			cstate_q       <= CS_IDLE;
			entry_time_q   <= '0;
			last_cut_q     <= '0;
			holdoff_left_q <= '0;
			reason_q       <= RS_OK;
			idx_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				case (cfg_ch.payload.index)
					REG_OPTION_BITS:    option_q     <= cfg_ch.payload.data[2:0];
					REG_MANUAL_CUT:     manual_cut_q <= cfg_ch.payload.data;
					REG_RPM_MINIMUM:    rpm_min_q    <= cfg_ch.payload.data;
					REG_BACKFIRE_RPM:   bf_rpm_q     <= cfg_ch.payload.data;
					REG_BACKFIRE_EXTRA: bf_extra_q   <= cfg_ch.payload.data;
					REG_HOLDOFF:        holdoff_q    <= cfg_ch.payload.data;
					REG_BAND_COUNT:     band_count_q <= cfg_ch.payload.data[3:0];
					default: ;
				endcase
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.step_idx) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.commit) begin
				cstate_q       <= cstate_d;
				entry_time_q   <= entry_time_d;
				last_cut_q     <= last_cut_d;
				holdoff_left_q <= holdoff_left_d;
				reason_q       <= reason_d;
				out_valid_q    <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ch.ready))
		else $error("result committed over an untaken result");
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && cmd.rd_en))
		else $error("band table written during a search read");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");
	a_fire_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.cut_fire) |->
		(out_q.machine_state == MS_RECOVER && out_q.reason_code == RS_CUTTING))
		else $error("cut fired without entering recover");
	a_fire_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.cut_fire && (CUT_MIN_C <= CUT_MAX_C)) |->
		(out_q.cut_length_ms >= CUT_MIN_C && out_q.cut_length_ms <= CUT_MAX_C))
		else $error("cut length outside clamp limits");
`endif
endmodule

FILE: src/shift_cut_sequencer_top.sv
// top level of the shift cut sequencer
// depends on scs_pkg, scs_if, scs_ctrl and scs_datapath
//
// in_ch takes one transaction at a time: a control tick (trigger, rpm,
// millisecond timestamp) or a write of one rpm band entry. every accepted
// transaction gives exactly one result transaction on out_ch.
// cfg_ch writes the configuration registers by index; it is always ready. the
// user must write it only while no transaction is in flight; the block does not enforce this.
// a result is registered by the commit in the done state, after the accepted
// transaction passes the evaluate state. a tick that cuts in auto band mode
// first walks the band table through the single ram read port, with a read
// state and a compare state per band visited, at most the band count in use.
// the next item is accepted only when the controller is back in idle after the commit.
// the result sits in an output register: a new item is accepted and worked
// on while out_ch stalls, and only its final commit waits for the register.
// reset clears the configuration to its defaults and the sequence to idle;
// band entries hold nothing until written and must be written before use.
module shift_cut_sequencer_top import scs_pkg::*; #(
	parameter int BAND_DEPTH = 8,
	parameter int CUT_MIN_MS = 10,
	parameter int CUT_MAX_MS = 200
) (
	input  logic      clk,
	input  logic      arst_n,
	scs_in_if.sink    in_ch,
	scs_out_if.source out_ch,
	scs_cfg_if.sink   cfg_ch
);
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	scs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	scs_datapath #(
		.BAND_DEPTH(BAND_DEPTH),
		.CUT_MIN_MS(CUT_MIN_MS),
		.CUT_MAX_MS(CUT_MAX_MS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch),
		.cmd   (cmd),
		.sts   (sts)
	);
endmodule
